/* rtl/acs_pkg.sv */
// Shared types, codes and helper functions of the ADC conversion scan controller.
package acs_pkg;

    localparam int unsigned CHAN_W    = 5;
    localparam int unsigned SAMPLE_W  = 10;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned POS_W     = 3;
    localparam int unsigned LIST_W    = 40;
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned APB_AW    = 5;
    localparam int unsigned APB_DW    = 64;
    localparam logic [LEN_W-1:0] MAX_CHAIN = 4'd8;

    typedef enum logic [2:0] {
        CMD_POLL  = 3'd0,
        CMD_IRQ   = 3'd1,
        CMD_CHAIN = 3'd2,
        CMD_DONE  = 3'd3,
        CMD_TICK  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_TIMEOUT = 2'd2
    } status_t;

    // Active conversion mode, one-hot
    typedef enum logic [3:0] {
        MODE_NONE   = 4'b0001,
        MODE_POLLED = 4'b0010,
        MODE_IRQ    = 4'b0100,
        MODE_CHAIN  = 4'b1000
    } mode_t;

    typedef enum logic [1:0] {
        REG_CHAIN_LEN  = 2'd0,
        REG_CHAIN_LIST = 2'd1,
        REG_WIDTH_MODE = 2'd2,
        REG_TIMEOUT    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0]  chain_length;
        logic [LIST_W-1:0] chain_channel_list;
        logic              result_width_mode;
        logic [TICK_W-1:0] timeout_ticks;
    } cfg_t;

    function automatic logic [CHAN_W-1:0] list_entry(
        input logic [LIST_W-1:0] list,
        input logic [POS_W-1:0]  pos
    );
        logic [5:0] base;
        base = 6'(pos) * 6'd5;
        return list[base +: CHAN_W];
    endfunction

    function automatic logic [SAMPLE_W-1:0] shape_reading(
        input logic [SAMPLE_W-1:0] sample,
        input logic                top_only
    );
        return top_only ? {2'b00, sample[SAMPLE_W-1:2]} : sample;
    endfunction

endpackage

/* rtl/acs_cmd_if.sv */
// Command channel: start commands and converter events into the controller.
interface acs_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    cmd;
    logic [acs_pkg::CHAN_W-1:0]    channel;
    logic [acs_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output cmd, output channel, output sample, input ready);
    modport sink   (input valid, input cmd, input channel, input sample, output ready);
endinterface

/* rtl/acs_res_if.sv */
// Result channel: one result transaction per command.
interface acs_res_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic                          start_conversion;
    logic [acs_pkg::CHAN_W-1:0]    conversion_channel;
    logic                          reading_valid;
    logic [acs_pkg::SAMPLE_W-1:0]  reading;
    logic [acs_pkg::POS_W-1:0]     reading_index;
    logic                          done_res;

    modport source (output valid, output status, output start_conversion,
                    output conversion_channel, output reading_valid, output reading,
                    output reading_index, output done_res, input ready);
    modport sink   (input valid, input status, input start_conversion,
                    input conversion_channel, input reading_valid, input reading,
                    input reading_index, input done_res, output ready);
endinterface

/* rtl/adc_conversion_scan_controller_core.sv */
// An accepted command is held in the input register; the result register holds its
// result for rsp. Throughput: one command per cycle while rsp takes results; the two
// registers decouple the channels, so a new command can still be taken while a
// result waits. Rate is set by the single state-update stage between those registers.
// Reset (rst_n low, asynchronous): idle, no mode, chain position and tick count 0,
// configuration registers at their reset values; no clearing pass.
module adc_conversion_scan_controller_core (
    input  logic                         clk,
    input  logic                         rst_n,
    acs_cmd_if.sink                      req,
    acs_res_if.source                    rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [acs_pkg::APB_AW-1:0]   paddr,
    input  logic [acs_pkg::APB_DW-1:0]   pwdata,
    output logic [acs_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import acs_pkg::*;

    cfg_t cfg;

    acs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    acs_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

/* rtl/acs_regs.sv */
// APB configuration register file.
module acs_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [acs_pkg::APB_AW-1:0]   paddr,
    input  logic [acs_pkg::APB_DW-1:0]   pwdata,
    output logic [acs_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output acs_pkg::cfg_t                cfg
);
    import acs_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_AW-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chain_length       <= 4'd1;
            cfg_reg.chain_channel_list <= '0;
            cfg_reg.result_width_mode  <= 1'b0;
            cfg_reg.timeout_ticks      <= 32'd50000;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_CHAIN_LEN:  cfg_reg.chain_length       <= pwdata[LEN_W-1:0];
                REG_CHAIN_LIST: cfg_reg.chain_channel_list <= pwdata[LIST_W-1:0];
                REG_WIDTH_MODE: cfg_reg.result_width_mode  <= pwdata[0];
                REG_TIMEOUT:    cfg_reg.timeout_ticks      <= pwdata[TICK_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_CHAIN_LEN:  prdata = APB_DW'(cfg_reg.chain_length);
            REG_CHAIN_LIST: prdata = APB_DW'(cfg_reg.chain_channel_list);
            REG_WIDTH_MODE: prdata = APB_DW'(cfg_reg.result_width_mode);
            REG_TIMEOUT:    prdata = APB_DW'(cfg_reg.timeout_ticks);
            default:        prdata = '0;
        endcase
    end

endmodule

/* rtl/acs_seq.sv */
// Conversion sequencer: input register, state update and result register.
module acs_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  acs_pkg::cfg_t cfg,
    acs_cmd_if.sink       req,
    acs_res_if.source     rsp
);
    import acs_pkg::*;

    // input stage
    logic                in_valid_reg;
    logic [2:0]          cmd_reg;
    logic [CHAN_W-1:0]   channel_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    // controller state
    mode_t             mode_reg, mode_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  run_len_reg, run_len_next;
    logic [TICK_W-1:0] wait_reg, wait_next;

    // result stage
    logic                out_valid_reg;
    logic [1:0]          status_reg, status_next;
    logic                start_reg, start_next;
    logic [CHAN_W-1:0]   cchan_reg, cchan_next;
    logic                rvalid_reg, rvalid_next;
    logic [SAMPLE_W-1:0] reading_reg, reading_next;
    logic [POS_W-1:0]    ridx_reg, ridx_next;
    logic                done_reg, done_next;

    logic              advance;
    logic              busy;
    logic [LEN_W-1:0]  len_clamped;
    logic [LEN_W-1:0]  pos_inc;
    logic [TICK_W-1:0] wait_inc;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign busy      = (mode_reg != MODE_NONE);
    assign pos_inc   = pos_reg + 4'd1;
    assign wait_inc  = wait_reg + 32'd1;

    always_comb
    begin
        len_clamped = cfg.chain_length;
        if (len_clamped == '0)
            len_clamped = 4'd1;
        else if (len_clamped > MAX_CHAIN)
            len_clamped = MAX_CHAIN;
    end

    always_comb
    begin
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        run_len_next = run_len_reg;
        wait_next    = wait_reg;
        status_next  = ST_OK;
        start_next   = 1'b0;
        cchan_next   = '0;
        rvalid_next  = 1'b0;
        reading_next = '0;
        ridx_next    = '0;
        done_next    = 1'b0;

        case (cmd_reg) inside
            CMD_POLL, CMD_IRQ, CMD_CHAIN:
            begin
                if (busy)
                    status_next = ST_BUSY;
                else
                begin
                    start_next = 1'b1;
                    wait_next  = '0;
                    pos_next   = '0;
                    if (cmd_reg == CMD_POLL)
                    begin
                        mode_next  = MODE_POLLED;
                        cchan_next = channel_reg;
                    end
                    else if (cmd_reg == CMD_IRQ)
                    begin
                        mode_next  = MODE_IRQ;
                        cchan_next = channel_reg;
                    end
                    else
                    begin
                        mode_next    = MODE_CHAIN;
                        run_len_next = len_clamped;
                        cchan_next   = list_entry(cfg.chain_channel_list, '0);
                    end
                end
            end
            CMD_DONE:
            begin
                if (busy)
                begin
                    rvalid_next  = 1'b1;
                    reading_next = shape_reading(sample_reg, cfg.result_width_mode);
                    if (mode_reg == MODE_CHAIN)
                    begin
                        ridx_next = pos_reg[POS_W-1:0];
                        if (pos_inc >= run_len_reg)
                        begin
                            done_next = 1'b1;
                            mode_next = MODE_NONE;
                            pos_next  = '0;
                        end
                        else
                        begin
                            // launch the next channel of the list
                            pos_next   = pos_inc;
                            start_next = 1'b1;
                            cchan_next = list_entry(cfg.chain_channel_list,
                                                    pos_inc[POS_W-1:0]);
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                        mode_next = MODE_NONE;
                    end
                end
            end
            CMD_TICK:
            begin
                if (mode_reg == MODE_POLLED)
                begin
                    wait_next = wait_inc;
                    if (wait_inc >= cfg.timeout_ticks)
                    begin
                        status_next = ST_TIMEOUT;
                        mode_next   = MODE_NONE;
                        wait_next   = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_NONE;
            pos_reg       <= '0;
            run_len_reg   <= 4'd1;
            wait_reg      <= '0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                pos_reg       <= pos_next;
                run_len_reg   <= run_len_next;
                wait_reg      <= wait_next;
            end
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            cmd_reg     <= req.cmd;
            channel_reg <= req.channel;
            sample_reg  <= req.sample;
        end
        if (advance)
        begin
            status_reg  <= status_next;
            start_reg   <= start_next;
            cchan_reg   <= cchan_next;
            rvalid_reg  <= rvalid_next;
            reading_reg <= reading_next;
            ridx_reg    <= ridx_next;
            done_reg    <= done_next;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = status_reg;
    assign rsp.start_conversion   = start_reg;
    assign rsp.conversion_channel = cchan_reg;
    assign rsp.reading_valid      = rvalid_reg;
    assign rsp.reading            = reading_reg;
    assign rsp.reading_index      = ridx_reg;
    assign rsp.done_res           = done_reg;

endmodule
